// ----- rtl/mct_pkg.sv -----
// Shared types, constants and queue sizes of the 4x4 column transform.
package mct_pkg;

    localparam int QW      = 32;               // Q16.16 word width
    localparam int FRAC    = 16;               // fraction bits
    localparam int DIM     = 4;                // rows and columns of the matrix
    localparam int COLW    = $clog2(DIM);
    localparam int PRODW   = 2 * QW;           // full product width
    localparam int SUMW    = PRODW - FRAC + 2; // four truncated products, added exactly

    // Queue depths must be powers of two: the pointers wrap on their own.
    localparam int QDEPTH  = 4;                // command queue, front to back
    localparam int QPTRW   = $clog2(QDEPTH);
    localparam int QCNTW   = $clog2(QDEPTH + 1);
    localparam int ODEPTH  = 4;                // result queue
    localparam int OPTRW   = $clog2(ODEPTH);
    localparam int OCNTW   = $clog2(ODEPTH + 1);

    localparam logic [QW-1:0] Q_ONE  = QW'(1) << FRAC;
    localparam logic [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] Q_MIN  = {1'b1, {(QW-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MUL  = 1'b1;

    typedef logic [QW-1:0] t_q;

    typedef struct packed {
        logic              op;
        logic [COLW-1:0]   column;
        logic signed [31:0] elem_0;
        logic signed [31:0] elem_1;
        logic signed [31:0] elem_2;
        logic signed [31:0] elem_3;
    } t_in_word;

    typedef struct packed {
        logic [COLW-1:0]    out_column;
        logic signed [31:0] res_0;
        logic signed [31:0] res_1;
        logic signed [31:0] res_2;
        logic signed [31:0] res_3;
        logic               saturated;
    } t_out_word;

    // Classified command as it travels from front to back.
    typedef struct packed {
        logic            is_mul;
        logic [COLW-1:0] column;
        t_q [DIM-1:0]    elem;
    } t_cmd;

    // Front-to-back channel.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

// ----- rtl/mct_front.sv -----
// Front end: accepts input words, classifies them and queues commands for the back end.
module mct_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mct_pkg::t_in_word   i_item,
    output mct_pkg::t_cmd_chan  o_chan,
    input  logic                i_chan_ready
);
    import mct_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QPTRW-1:0]  r_wp, n_wp;
    logic [QPTRW-1:0]  r_rp, n_rp;
    logic [QCNTW-1:0]  r_cnt, n_cnt;
    logic              wr, rd;
    t_cmd              cmd_in;

    // Classify the incoming word.
    always_comb begin
        cmd_in.is_mul  = (i_item.op == OP_MUL);
        cmd_in.column  = i_item.column;
        cmd_in.elem[0] = i_item.elem_0;
        cmd_in.elem[1] = i_item.elem_1;
        cmd_in.elem[2] = i_item.elem_2;
        cmd_in.elem[3] = i_item.elem_3;
    end

    assign full         = (r_cnt == QCNTW'(QDEPTH));
    assign wr           = push && !full;
    assign rd           = o_chan.valid && i_chan_ready;
    assign o_chan.valid = (r_cnt != '0);
    assign o_chan.cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = wr ? r_wp + 1'b1 : r_wp;
        n_rp  = rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ----- rtl/mct_back.sv -----
// Back end: holds matrix A, applies loads, runs the multiply pipeline and the result queue.
module mct_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mct_pkg::t_cmd_chan  i_chan,
    output logic                o_chan_ready,
    output logic                empty,
    input  logic                pop,
    output mct_pkg::t_out_word  o_result
);
    import mct_pkg::*;

    t_q                       r_mat [DIM][DIM];      // [column][row]
    logic                     r_s1_vld;
    logic [COLW-1:0]          r_s1_col;
    logic signed [PRODW-1:0]  r_prod [DIM][DIM];     // [row][k]
    logic                     r_s2_vld;
    t_out_word                r_s2, n_s2;
    t_out_word                r_oq [ODEPTH];
    logic [OPTRW-1:0]         r_owp, r_orp;
    logic [OCNTW-1:0]         r_ocnt, n_ocnt;
    logic [OCNTW:0]           slots_used;
    logic                     take, owr, ord;
    logic signed [SUMW-1:0]   sum [DIM];
    t_q                       res [DIM];
    logic [DIM-1:0]           sat;

    // Reserve a result slot for every word in flight so the pipeline never stalls.
    assign slots_used   = (OCNTW+1)'(r_ocnt) + (OCNTW+1)'(r_s1_vld) + (OCNTW+1)'(r_s2_vld);
    assign o_chan_ready = (slots_used < (OCNTW+1)'(ODEPTH));
    assign take         = i_chan.valid && o_chan_ready;

    // Matrix store: reset to identity, overwrite a column on a load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < DIM; c++) begin
                for (int r = 0; r < DIM; r++) begin
                    r_mat[c][r] <= (c == r) ? Q_ONE : '0;
                end
            end
        end else if (take && !i_chan.cmd.is_mul) begin
            for (int r = 0; r < DIM; r++) begin
                r_mat[i_chan.cmd.column][r] <= i_chan.cmd.elem[r];
            end
        end
    end

    // Stage 1: sixteen full products.
    always_ff @(posedge i_clk) begin
        if (take && i_chan.cmd.is_mul) begin
            r_s1_col <= i_chan.cmd.column;
            for (int j = 0; j < DIM; j++) begin
                for (int k = 0; k < DIM; k++) begin
                    r_prod[j][k] <= $signed(r_mat[k][j]) * $signed(i_chan.cmd.elem[k]);
                end
            end
        end
    end

    // Stage 2: floor each product to Q16.16, add and clip.
    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            sum[j] = '0;
            for (int k = 0; k < DIM; k++) begin
                sum[j] = sum[j] + SUMW'(r_prod[j][k] >>> FRAC);
            end
            sat[j] = !((&sum[j][SUMW-1:QW-1]) || !(|sum[j][SUMW-1:QW-1]));
            if (!sat[j]) begin
                res[j] = sum[j][QW-1:0];
            end else if (sum[j][SUMW-1]) begin
                res[j] = Q_MIN;
            end else begin
                res[j] = Q_MAX;
            end
        end
        n_s2.out_column = r_s1_col;
        n_s2.res_0      = res[0];
        n_s2.res_1      = res[1];
        n_s2.res_2      = res[2];
        n_s2.res_3      = res[3];
        n_s2.saturated  = |sat;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= take && i_chan.cmd.is_mul;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Result queue.
    assign owr      = r_s2_vld;
    assign empty    = (r_ocnt == '0);
    assign ord      = pop && !empty;
    assign o_result = r_oq[r_orp];

    always_comb begin
        n_ocnt = r_ocnt;
        if (owr && !ord) begin
            n_ocnt = r_ocnt + 1'b1;
        end else if (ord && !owr) begin
            n_ocnt = r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (owr) begin
                r_owp <= r_owp + 1'b1;
            end
            if (ord) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (owr) begin
            r_oq[r_owp] <= r_s2;
        end
    end

endmodule

// ----- rtl/mat4_column_transform.sv -----
// Top level of the 4x4 matrix by column transform in signed Q16.16.
//
// The block keeps a 4x4 matrix A, reset to the identity. A load word (op = 0)
// overwrites column "column" of A and returns nothing. A multiply word (op = 1)
// carries column i of a matrix B and returns column i of A*B: each row is the
// sum of four 32x32 products, each floored to Q16.16, then clipped to the
// signed 32-bit range, with "saturated" set when any row clipped. Both sides
// behave as queues: push a word while full is low, pop a result while empty
// is low. One word is taken every clock cycle when the result side keeps up.
// A multiply result passes the command queue, the product stage and the sum
// stage before it is written to the result queue, and can be popped
// from the cycle after that; the rate is one word per cycle, set by the
// sixteen parallel multipliers of the product stage. Loads take effect in
// order, so a multiply always sees every load pushed before it.
module mat4_column_transform (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mct_pkg::t_in_word   i_item,
    output logic                empty,
    input  logic                pop,
    output mct_pkg::t_out_word  o_result
);
    import mct_pkg::*;

    t_cmd_chan chan;
    logic      chan_ready;

    // Front: accept and classify, queue commands.
    mct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (i_item),
        .o_chan       (chan),
        .i_chan_ready (chan_ready)
    );

    // Back: apply loads, multiply, clip and hold results until popped.
    mct_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_chan       (chan),
        .o_chan_ready (chan_ready),
        .empty        (empty),
        .pop          (pop),
        .o_result     (o_result)
    );

endmodule

// ----- tb/tb_mat4_column_transform.sv -----
// Self-checking testbench for the 4x4 Q16.16 matrix by column transform.
`timescale 1ns / 100ps

import mct_pkg::*;

class mat_product_scoreboard;

    localparam longint ROW_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ROW_MIN = -64'sh0000_0000_8000_0000;

    logic signed [31:0] left_cols [DIM][DIM];   // [column][row]
    t_out_word          expected_columns [$];
    int unsigned        field_errors;
    int unsigned        loads_seen;
    int unsigned        muls_seen;
    int unsigned        clipped_seen;
    int unsigned        columns_checked;

    function new();
        for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
                left_cols[c][r] = (c == r) ? Q_ONE : '0;
            end
        end
        field_errors    = 0;
        loads_seen      = 0;
        muls_seen       = 0;
        clipped_seen    = 0;
        columns_checked = 0;
    endfunction

    // Update the stored matrix on a load, or queue the product column on a multiply.
    function void note_word(t_in_word w);
        logic signed [31:0] b [DIM];
        logic signed [31:0] rows [DIM];
        longint             acc;
        logic               clipped;
        t_out_word          want;
        b[0] = w.elem_0;
        b[1] = w.elem_1;
        b[2] = w.elem_2;
        b[3] = w.elem_3;
        if (w.op == OP_LOAD) begin
            for (int k = 0; k < DIM; k++) begin
                left_cols[w.column][k] = b[k];
            end
            loads_seen++;
            return;
        end
        clipped = 1'b0;
        for (int j = 0; j < DIM; j++) begin
            acc = 0;
            for (int k = 0; k < DIM; k++) begin
                acc += (longint'(left_cols[k][j]) * longint'(b[k])) >>> FRAC;
            end
            if (acc > ROW_MAX) begin
                acc     = ROW_MAX;
                clipped = 1'b1;
            end else if (acc < ROW_MIN) begin
                acc     = ROW_MIN;
                clipped = 1'b1;
            end
            rows[j] = acc[31:0];
        end
        want.out_column = w.column;
        want.res_0      = rows[0];
        want.res_1      = rows[1];
        want.res_2      = rows[2];
        want.res_3      = rows[3];
        want.saturated  = clipped;
        expected_columns.push_back(want);
        muls_seen++;
        if (clipped) clipped_seen++;
    endfunction

    function void check_column(t_out_word got);
        t_out_word          want;
        logic signed [31:0] want_rows [DIM];
        logic signed [31:0] got_rows [DIM];
        if (expected_columns.size() == 0) begin
            $error("result word with nothing pending: out_column %0d", got.out_column);
            field_errors++;
            return;
        end
        want = expected_columns.pop_front();
        columns_checked++;
        want_rows = '{want.res_0, want.res_1, want.res_2, want.res_3};
        got_rows  = '{got.res_0, got.res_1, got.res_2, got.res_3};
        if (got.out_column !== want.out_column) begin
            $error("out_column: expected %0d, actual %0d", want.out_column, got.out_column);
            field_errors++;
        end
        for (int j = 0; j < DIM; j++) begin
            if (got_rows[j] !== want_rows[j]) begin
                $error("res_%0d: expected %h, actual %h", j, want_rows[j], got_rows[j]);
                field_errors++;
            end
        end
        if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
            field_errors++;
        end
    endfunction

endclass

module tb_mat4_column_transform;

    localparam int WATCHDOG_CYCLES = 3000;  // cycles with no word moving on either side
    localparam int PIPE_CYCLES     = 10;    // drain margin past the pipeline
    localparam int PHASE_WORDS     = 475;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off, fills every queue

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    logic      empty;
    logic      pop;
    t_in_word  i_item;
    t_out_word o_result;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    int unsigned input_stalls   = 0;

    mat_product_scoreboard products;

    mat4_column_transform u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_in_word make_word(logic op, int col, t_q e0, t_q e1, t_q e2, t_q e3);
        t_in_word w;
        w.op     = op;
        w.column = col[COLW-1:0];
        w.elem_0 = e0;
        w.elem_1 = e1;
        w.elem_2 = e2;
        w.elem_3 = e3;
        return w;
    endfunction

    // Mix small values (sums stay in range), medium values, plus or minus one, full-range noise and the corner values.
    function automatic t_q random_elem();
        case ($urandom_range(9))
            0, 1, 2: return t_q'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
            3, 4:    return t_q'($urandom());
            5: begin
                case ($urandom_range(4))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return t_q'(1);
                endcase
            end
            6:       return $urandom_range(1) ? Q_ONE : t_q'(-Q_ONE);
            7:       return t_q'($urandom_range(32'h0200_0000)) - 32'h0100_0000;
            default: return t_q'($urandom());
        endcase
    endfunction

    // Offer one word, idling first at the sender's rate; hold it until full drops.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= w;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        products.note_word(w);
    endtask

    // Stop offering and hold until every pending product column has come back.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (products.expected_columns.size() != 0);
    endtask

    // Result side: check the word popped at this edge, then pick the next pop.
    // A pending hold-off is counted down here, one cycle at a time.
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) products.check_column(o_result);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which no word moves on either side; note input stalls.
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle_run = 0;
            else idle_run++;
            if (push && full) input_stalls++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_in_word w;
        i_rst_n  <= 1'b0;
        push     <= 1'b0;
        i_item   <= '0;
        products = new();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity after reset: each column passes through unchanged, extremes included.
        send_word(make_word(OP_MUL, 0, Q_MAX, Q_MIN, t_q'(1), '1));
        send_word(make_word(OP_MUL, 1, '0, '0, '0, '0));
        send_word(make_word(OP_MUL, 2, '1, '1, '1, '1));
        send_word(make_word(OP_MUL, 3, Q_ONE, t_q'(-Q_ONE), 32'h0000_8000, 32'h7FFF_0000));

        // Full-scale columns: clip high, clip low, and large products that cancel to in-range sums.
        send_word(make_word(OP_LOAD, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_word(make_word(OP_LOAD, 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_word(make_word(OP_MUL, 0, Q_MAX, Q_MAX, '0, '0));
        send_word(make_word(OP_LOAD, 1, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_word(make_word(OP_MUL, 1, Q_MAX, Q_MAX, '0, '0));
        send_word(make_word(OP_MUL, 2, '0, Q_MAX, '0, '0));
        send_word(make_word(OP_MUL, 3, Q_MIN, Q_MIN, '0, '0));

        // One-LSB products: a negative product floors to minus one LSB.
        send_word(make_word(OP_LOAD, 2, '1, '1, '1, '1));
        send_word(make_word(OP_LOAD, 3, t_q'(1), t_q'(1), t_q'(1), t_q'(1)));
        send_word(make_word(OP_MUL, 0, '0, '0, t_q'(1), '0));
        send_word(make_word(OP_MUL, 1, '0, '0, '0, '1));
        send_word(make_word(OP_MUL, 2, '0, '0, '1, '0));
        send_word(make_word(OP_MUL, 3, '0, '0, t_q'(1), t_q'(1)));

        // Row sums one LSB past each limit, and exactly on the lower one.
        send_word(make_word(OP_LOAD, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_word(make_word(OP_LOAD, 1, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        send_word(make_word(OP_MUL, 0, Q_MAX, t_q'(1), '0, '0));
        send_word(make_word(OP_MUL, 1, Q_MIN, '1, '0, '0));
        send_word(make_word(OP_MUL, 2, Q_MIN, '0, '0, '0));
        drain_results();

        // Random words under four idle mixes; drain between mixes.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // Hold off the result side while words keep coming, so full rises.
                if (phase == 0 && n == 100) hold_left = HOLD_CYCLES;
                w = make_word(($urandom_range(99) < 30) ? OP_LOAD : OP_MUL,
                              $urandom_range(DIM - 1),
                              random_elem(), random_elem(), random_elem(), random_elem());
                send_word(w);
            end
            drain_results();
        end

        repeat (PIPE_CYCLES) @(posedge i_clk);

        $display("covered %0d column loads and %0d multiplies (%0d clipped) over four idle mixes",
                 products.loads_seen, products.muls_seen, products.clipped_seen);
        $display("checked %0d product columns; push held off by full for %0d cycles",
                 products.columns_checked, input_stalls);
        if (products.field_errors == 0 && products.expected_columns.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
